### rtl/rgyuv_pkg.sv
// Shared types, constants and helpers for the RGB to planar YUV 4:2:0 writer.
// No dependencies; every other file in rtl/ refers to this package by scope.
package rgyuv_pkg;

  // Field widths
  localparam int CFG_W  = 13;   // frame size registers
  localparam int ADDR_W = 25;   // byte offset into the planar frame buffer
  localparam int BYTE_W = 8;    // one sample
  localparam int SUM_W  = 27;   // signed Q16 color sum

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the frame size registers
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Full-range BT.601 coefficients, Q0.16 rounded to nearest
  localparam logic signed [17:0] KY_R =  18'sd19595;
  localparam logic signed [17:0] KY_G =  18'sd38470;
  localparam logic signed [17:0] KY_B =  18'sd7471;
  localparam logic signed [17:0] KU_R = -18'sd11058;
  localparam logic signed [17:0] KU_G = -18'sd21710;
  localparam logic signed [17:0] KU_B =  18'sd32768;
  localparam logic signed [17:0] KV_R =  18'sd32768;
  localparam logic signed [17:0] KV_G = -18'sd27439;
  localparam logic signed [17:0] KV_B = -18'sd5329;

  // Chroma offset of 128 and top of range 255, both in Q16
  localparam logic signed [SUM_W-1:0] OFS_Q16 = 27'sd8388608;
  localparam logic signed [SUM_W-1:0] TOP_Q16 = 27'sd16711680;

  // Plane codes on the result channel
  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // Position flags of the pixel being taken in
  typedef struct packed {
    logic chroma;      // even column and even row
    logic last_frame;  // bottom-right pixel of the frame
  } pix_flags_t;

  // Everything one pixel writes, held until its last byte is taken
  typedef struct packed {
    logic [ADDR_W-1:0] y_addr;
    logic [ADDR_W-1:0] u_addr;
    logic [ADDR_W-1:0] v_addr;
    logic [BYTE_W-1:0] y_val;
    logic [BYTE_W-1:0] u_val;
    logic [BYTE_W-1:0] v_val;
    pix_flags_t        flags;
  } pix_result_t;

  // Clamp a Q16 sum to 0..255 and drop the fraction
  function automatic logic [BYTE_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] s);
    logic [BYTE_W-1:0] v;
    if (s < 0) begin
      v = '0;
    end else if (s > TOP_Q16) begin
      v = '1;
    end else begin
      v = s[23:16];
    end
    return v;
  endfunction

endpackage

### rtl/rgyuv_raster.sv
// Frame size registers, size fitting and the raster column/row counters.
// Depends on rgyuv_pkg.
module rgyuv_raster #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [rgyuv_pkg::CFG_W-1:0] cfg_data,
  input  logic                      advance,
  output logic [CW-1:0]             pos_x,
  output logic [RW-1:0]             pos_y,
  output logic [WW-1:0]             eff_w,
  output logic [HW-1:0]             eff_h,
  output rgyuv_pkg::pix_flags_t     flags
);

  localparam int FWW = ((WW > rgyuv_pkg::CFG_W) ? WW : rgyuv_pkg::CFG_W) + 1;
  localparam int FHW = ((HW > rgyuv_pkg::CFG_W) ? HW : rgyuv_pkg::CFG_W) + 1;

  logic [rgyuv_pkg::CFG_W-1:0] frame_width;
  logic [rgyuv_pkg::CFG_W-1:0] frame_height;
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;

  logic [FWW-1:0] fit_w;
  logic [FHW-1:0] fit_h;
  logic [WW-1:0]  x_ext, x_inc;
  logic [HW-1:0]  y_ext, y_inc;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgyuv_pkg::FRAME_WIDTH_RST;
      frame_height <= rgyuv_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        rgyuv_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        rgyuv_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate sizes to 2..MAX and force them even
  always_comb begin
    fit_w = FWW'(frame_width);
    if (fit_w < FWW'(2)) fit_w = FWW'(2);
    if (fit_w > FWW'(MAX_WIDTH)) fit_w = FWW'(MAX_WIDTH);
    fit_h = FHW'(frame_height);
    if (fit_h < FHW'(2)) fit_h = FHW'(2);
    if (fit_h > FHW'(MAX_HEIGHT)) fit_h = FHW'(MAX_HEIGHT);
    eff_w = {fit_w[WW-1:1], 1'b0};
    eff_h = {fit_h[HW-1:1], 1'b0};
  end

  // Place the current pixel; a count beyond a shrunk frame wraps first
  always_comb begin
    x_ext = WW'(column_count);
    y_ext = HW'(row_count);
    if (x_ext >= eff_w) begin
      x_ext = '0;
      y_ext = y_ext + HW'(1);
    end
    if (y_ext >= eff_h) begin
      y_ext = '0;
    end
    pos_x = x_ext[CW-1:0];
    pos_y = y_ext[RW-1:0];
    flags.chroma     = !x_ext[0] && !y_ext[0];
    flags.last_frame = (x_ext == eff_w - WW'(1)) && (y_ext == eff_h - HW'(1));
  end

  // Step to the next raster position
  always_comb begin
    x_inc = x_ext + WW'(1);
    y_inc = y_ext + HW'(1);
    if (x_inc >= eff_w) begin
      column_count_next = '0;
      if (y_inc >= eff_h) begin
        row_count_next = '0;
      end else begin
        row_count_next = y_inc[RW-1:0];
      end
    end else begin
      column_count_next = x_inc[CW-1:0];
      row_count_next    = y_ext[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

### rtl/rgyuv_color.sv
// RGB to full-range BT.601 YUV in Q16 fixed point, clamped to bytes.
// Depends on rgyuv_pkg (coefficients and clamp_q16).
module rgyuv_color (
  input  logic [rgyuv_pkg::BYTE_W-1:0] red,
  input  logic [rgyuv_pkg::BYTE_W-1:0] green,
  input  logic [rgyuv_pkg::BYTE_W-1:0] blue,
  output logic [rgyuv_pkg::BYTE_W-1:0] y_val,
  output logic [rgyuv_pkg::BYTE_W-1:0] u_val,
  output logic [rgyuv_pkg::BYTE_W-1:0] v_val
);

  localparam int SW = rgyuv_pkg::SUM_W;

  logic signed [SW-1:0] r_s, g_s, b_s;
  logic signed [SW-1:0] y_sum, u_sum, v_sum;

  // Widen the components to signed sums
  assign r_s = SW'($signed({1'b0, red}));
  assign g_s = SW'($signed({1'b0, green}));
  assign b_s = SW'($signed({1'b0, blue}));

  // Weighted sums; chroma carries the 128 offset
  assign y_sum = r_s * SW'(rgyuv_pkg::KY_R) + g_s * SW'(rgyuv_pkg::KY_G)
               + b_s * SW'(rgyuv_pkg::KY_B);
  assign u_sum = r_s * SW'(rgyuv_pkg::KU_R) + g_s * SW'(rgyuv_pkg::KU_G)
               + b_s * SW'(rgyuv_pkg::KU_B) + rgyuv_pkg::OFS_Q16;
  assign v_sum = r_s * SW'(rgyuv_pkg::KV_R) + g_s * SW'(rgyuv_pkg::KV_G)
               + b_s * SW'(rgyuv_pkg::KV_B) + rgyuv_pkg::OFS_Q16;

  // Clamp and truncate
  assign y_val = rgyuv_pkg::clamp_q16(y_sum);
  assign u_val = rgyuv_pkg::clamp_q16(u_sum);
  assign v_val = rgyuv_pkg::clamp_q16(v_sum);

endmodule

### rtl/rgyuv_emit.sv
// Result buffer: holds one pixel's bytes and sends Y, then U and V for chroma
// pixels, one request per cycle while out_ready is high. Depends on rgyuv_pkg.
module rgyuv_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  input  rgyuv_pkg::pix_result_t        pix,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgyuv_pkg::ADDR_W-1:0]  byte_address,
  output logic [rgyuv_pkg::BYTE_W-1:0]  byte_value,
  output logic [1:0]                    plane,
  output logic                          last_of_pixel,
  output logic                          last_of_frame
);

  rgyuv_pkg::pix_result_t held;
  logic                   full, full_next;
  rgyuv_pkg::plane_t      idx, idx_next;
  logic                   last_result;
  logic                   sent;
  logic                   load;

  // Last request of the held pixel, and buffer turnover
  assign last_result = !held.flags.chroma || (idx == rgyuv_pkg::PLANE_V);
  assign sent        = full && out_ready;
  assign take        = !full || (sent && last_result);
  assign load        = pix_valid && take;

  // Advance through the planes, reload or drain
  always_comb begin
    full_next = full;
    idx_next  = idx;
    if (load) begin
      full_next = 1'b1;
      idx_next  = rgyuv_pkg::PLANE_Y;
    end else if (sent && last_result) begin
      full_next = 1'b0;
      idx_next  = rgyuv_pkg::PLANE_Y;
    end else if (sent) begin
      case (idx)
        rgyuv_pkg::PLANE_Y: idx_next = rgyuv_pkg::PLANE_U;
        rgyuv_pkg::PLANE_U: idx_next = rgyuv_pkg::PLANE_V;
        default:            idx_next = rgyuv_pkg::PLANE_Y;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= rgyuv_pkg::PLANE_Y;
    end else begin
      full <= full_next;
      idx  <= idx_next;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= pix;
    end
  end

  // Select the current request
  always_comb begin
    case (idx)
      rgyuv_pkg::PLANE_U: begin
        byte_address = held.u_addr;
        byte_value   = held.u_val;
      end
      rgyuv_pkg::PLANE_V: begin
        byte_address = held.v_addr;
        byte_value   = held.v_val;
      end
      default: begin
        byte_address = held.y_addr;
        byte_value   = held.y_val;
      end
    endcase
  end

  assign out_valid     = full;
  assign plane         = idx;
  assign last_of_pixel = last_result;
  assign last_of_frame = last_result && held.flags.last_frame;

`ifndef SYNTHESIS
  a_luma_only: assert property (@(posedge clk) disable iff (rst)
    (full && !held.flags.chroma) |-> (idx == rgyuv_pkg::PLANE_Y))
    else $error("non-chroma pixel left the luma plane");

  a_load_restart: assert property (@(posedge clk) disable iff (rst)
    load |=> (full && idx == rgyuv_pkg::PLANE_Y))
    else $error("new pixel did not start at luma");

  a_mid_pixel_holds: assert property (@(posedge clk) disable iff (rst)
    (sent && !last_result) |=> (full && idx != rgyuv_pkg::PLANE_Y))
    else $error("chroma sequence broken before its last request");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (sent && last_result && !pix_valid) |=> !full)
    else $error("buffer stayed full after its last request");
`endif

endmodule

### rtl/rgb_to_yuv420_planar_writer.sv
// Top level of the RGB to planar YUV 4:2:0 writer: input stage, address math
// and wiring. Depends on rgyuv_pkg, rgyuv_raster, rgyuv_color and rgyuv_emit.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   red, green, blue
//   out      out_valid / out_ready byte_address, byte_value, plane,
//                                  last_of_pixel, last_of_frame
//   cfg      cfg_write             cfg_index, cfg_data
//
// A pixel at odd column or odd row sends one request (Y), one at even column
// and even row sends three (Y, U, V); the single result port sets the rate at one
// request per cycle while out_ready is high, 1.5 requests per pixel over a frame.
// Accepted pixels go through the input stage register into the result buffer.
// Reset clears the counters, the buffers and sets the size to 640 x 480.
// A stalled out channel backs up the input stage, then drops in_ready.
module rgb_to_yuv420_planar_writer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [rgyuv_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rgyuv_pkg::BYTE_W-1:0]  red,
  input  logic [rgyuv_pkg::BYTE_W-1:0]  green,
  input  logic [rgyuv_pkg::BYTE_W-1:0]  blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgyuv_pkg::ADDR_W-1:0]  byte_address,
  output logic [rgyuv_pkg::BYTE_W-1:0]  byte_value,
  output logic [1:0]                    plane,
  output logic                          last_of_pixel,
  output logic                          last_of_frame
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = (HW + WW + 2 > rgyuv_pkg::ADDR_W) ? HW + WW + 2 : rgyuv_pkg::ADDR_W;

  logic                  accept;
  logic                  take;
  logic [CW-1:0]         pos_x;
  logic [RW-1:0]         pos_y;
  logic [WW-1:0]         eff_w;
  logic [HW-1:0]         eff_h;
  rgyuv_pkg::pix_flags_t flags;

  // Input stage
  logic                         s1_valid, s1_valid_next;
  logic [rgyuv_pkg::BYTE_W-1:0] s1_red, s1_green, s1_blue;
  logic [CW-1:0]                s1_x;
  logic [RW-1:0]                s1_y;
  logic [WW-1:0]                s1_w;
  logic [HW-1:0]                s1_h;
  rgyuv_pkg::pix_flags_t        s1_flags;

  logic [AW-1:0]                yw, area, cidx;
  logic [AW-1:0]                y_full, u_full, v_full;
  logic [rgyuv_pkg::BYTE_W-1:0] y_val, u_val, v_val;
  rgyuv_pkg::pix_result_t       pix;

  assign in_ready = !s1_valid || take;
  assign accept   = in_valid && in_ready;

  rgyuv_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .flags     (flags)
  );

  // Hold the accepted pixel with its position and frame size
  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (take) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
      s1_x     <= pos_x;
      s1_y     <= pos_y;
      s1_w     <= eff_w;
      s1_h     <= eff_h;
      s1_flags <= flags;
    end
  end

  // Plane addresses; for even row and even width, (y/2)*(w/2) is y*w/4
  assign yw     = AW'(s1_y) * AW'(s1_w);
  assign area   = AW'(s1_h) * AW'(s1_w);
  assign cidx   = (yw >> 2) + AW'(s1_x >> 1);
  assign y_full = yw + AW'(s1_x);
  assign u_full = area + cidx;
  assign v_full = area + (area >> 2) + cidx;

  rgyuv_color u_color (
    .red   (s1_red),
    .green (s1_green),
    .blue  (s1_blue),
    .y_val (y_val),
    .u_val (u_val),
    .v_val (v_val)
  );

  // Gather everything the pixel writes
  always_comb begin
    pix.y_addr = y_full[rgyuv_pkg::ADDR_W-1:0];
    pix.u_addr = u_full[rgyuv_pkg::ADDR_W-1:0];
    pix.v_addr = v_full[rgyuv_pkg::ADDR_W-1:0];
    pix.y_val  = y_val;
    pix.u_val  = u_val;
    pix.v_val  = v_val;
    pix.flags  = s1_flags;
  end

  rgyuv_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (s1_valid),
    .pix           (pix),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_address  (byte_address),
    .byte_value    (byte_value),
    .plane         (plane),
    .last_of_pixel (last_of_pixel),
    .last_of_frame (last_of_frame)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for rgb_to_yuv420_planar_writer: directed pixels, then random frames.
// A local BT.601 predictor models every expected byte write.
// Depends on rgyuv_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_DIM_W     = 4096;
  localparam int MAX_DIM_H     = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_PIXELS  = 40;
  localparam int PHASE_COUNT   = 8;

  // Register selects, short names for the stimulus table
  localparam logic SEL_WIDTH  = rgyuv_pkg::REG_FRAME_WIDTH;
  localparam logic SEL_HEIGHT = rgyuv_pkg::REG_FRAME_HEIGHT;

  // Q0.16 coefficients of full-range BT.601
  localparam int COEF_YR = 19595;
  localparam int COEF_YG = 38470;
  localparam int COEF_YB = 7471;
  localparam int COEF_UR = -11058;
  localparam int COEF_UG = -21710;
  localparam int COEF_UB = 32768;
  localparam int COEF_VR = 32768;
  localparam int COEF_VG = -27439;
  localparam int COEF_VB = -5329;
  localparam int CHROMA_OFS = 128 * 65536;
  localparam int SAMPLE_TOP = 255 * 65536;

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    row_kind_t   kind;
    logic        cfg_sel;
    logic [12:0] cfg_value;
    logic [7:0]  r, g, b;
    bit          typed;
    logic [7:0]  ey, eu, ev;
  } stim_row_t;

  typedef struct {
    logic [rgyuv_pkg::ADDR_W-1:0] addr;
    logic [7:0]                   value;
    rgyuv_pkg::plane_t            plane;
    logic                         lp;
    logic                         lf;
  } yuv_write_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic                          cfg_index;
  logic [rgyuv_pkg::CFG_W-1:0]   cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    red, green, blue;
  logic                          out_valid;
  logic                          out_ready;
  logic [rgyuv_pkg::ADDR_W-1:0]  byte_address;
  logic [7:0]                    byte_value;
  logic [1:0]                    plane;
  logic                          last_of_pixel;
  logic                          last_of_frame;

  // Predictor state
  logic [12:0] frame_width_reg  = 13'd640;
  logic [12:0] frame_height_reg = 13'd480;
  int          cur_col = 0;
  int          cur_row = 0;
  yuv_write_t  expected_writes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int error_count    = 0;
  int pixels_sent    = 0;
  int writes_checked = 0;
  int frames_done    = 0;
  int sizes_written  = 0;
  int cycle_count    = 0;

  // Corners: reset size, color extremes, shrink mid-frame, odd and out-of-range sizes
  stim_row_t directed_rows [26] = '{
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd128, 8'd128},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b1, 8'd76,  8'd84,  8'd255},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b1, 8'd149, 8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd0,   8'd0,   8'd255, 1'b1, 8'd29,  8'd255, 8'd107},
    '{ROW_CONFIG, SEL_WIDTH,  13'd2,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, SEL_HEIGHT, 13'd2,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd170, 8'd85,  8'd51,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd85,  8'd170, 8'd204, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd0,   8'd128, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, SEL_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, SEL_HEIGHT, 13'd1,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd128, 8'd128, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd255, 8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd0,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, SEL_WIDTH,  13'd8191, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, SEL_HEIGHT, 13'd4097, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd1,   8'd2,   8'd4,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd254, 8'd253, 8'd251, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, SEL_WIDTH,  13'd3,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_CONFIG, SEL_HEIGHT, 13'd5,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd16,  8'd32,  8'd64,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd127, 8'd127, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd200, 8'd100, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
    '{ROW_PIXEL,  SEL_WIDTH,  13'd0,    8'd50,  8'd100, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  rgb_to_yuv420_planar_writer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_address  (byte_address),
    .byte_value    (byte_value),
    .plane         (plane),
    .last_of_pixel (last_of_pixel),
    .last_of_frame (last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturate a size register to 2..max and force it even
  function automatic int fit_dim(input logic [12:0] reg_v, input int max_dim);
    int v;
    v = reg_v;
    if (v < 2) v = 2;
    if (v > max_dim) v = max_dim;
    v = v & ~1;
    if (v < 2) v = 2;
    return v;
  endfunction

  // Clamp a Q16 sum to one sample
  function automatic logic [7:0] q16_to_byte(input int s);
    if (s < 0) return 8'd0;
    if (s > SAMPLE_TOP) return 8'd255;
    return s[23:16];
  endfunction

  // Compute the writes one pixel causes and queue them; typed values override the bytes
  task automatic predict_pixel(input logic [7:0] r, g, b, input bit typed,
                               input logic [7:0] ty, tu, tv);
    int w, h, x, y, area, cidx, ri, gi, bi;
    bit chroma, last_px;
    yuv_write_t wr;
    w = fit_dim(frame_width_reg, MAX_DIM_W);
    h = fit_dim(frame_height_reg, MAX_DIM_H);
    ri = r;
    gi = g;
    bi = b;
    // Take counters beyond a shrunk frame as the start of the next row or frame
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    x = cur_col;
    y = cur_row;
    area = w * h;
    chroma = !x[0] && !y[0];
    last_px = (x == w - 1) && (y == h - 1);

    wr.addr  = rgyuv_pkg::ADDR_W'(y * w + x);
    wr.value = typed ? ty : q16_to_byte(COEF_YR * ri + COEF_YG * gi + COEF_YB * bi);
    wr.plane = rgyuv_pkg::PLANE_Y;
    wr.lp    = !chroma;
    wr.lf    = !chroma && last_px;
    expected_writes.push_back(wr);
    if (chroma) begin
      cidx = (y >> 1) * (w >> 1) + (x >> 1);
      wr.addr  = rgyuv_pkg::ADDR_W'(area + cidx);
      wr.value = typed ? tu :
                 q16_to_byte(COEF_UR * ri + COEF_UG * gi + COEF_UB * bi + CHROMA_OFS);
      wr.plane = rgyuv_pkg::PLANE_U;
      wr.lp    = 1'b0;
      wr.lf    = 1'b0;
      expected_writes.push_back(wr);
      wr.addr  = rgyuv_pkg::ADDR_W'(area + (area >> 2) + cidx);
      wr.value = typed ? tv :
                 q16_to_byte(COEF_VR * ri + COEF_VG * gi + COEF_VB * bi + CHROMA_OFS);
      wr.plane = rgyuv_pkg::PLANE_V;
      wr.lp    = 1'b1;
      wr.lf    = last_px;
      expected_writes.push_back(wr);
    end

    // Advance raster position
    cur_col = x + 1;
    cur_row = y;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = y + 1;
      if (cur_row >= h) cur_row = 0;
    end
  endtask

  // Offer one pixel, with random gaps; called and returns at a falling edge
  task automatic send_pixel(input logic [7:0] r, g, b, input bit typed,
                            input logic [7:0] ty, tu, tv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(r, g, b, typed, ty, tu, tv);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued write has come out, plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [12:0] value);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    if (sel == rgyuv_pkg::REG_FRAME_WIDTH) frame_width_reg = value;
    else frame_height_reg = value;
    sizes_written++;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly small even sizes so frames wrap often; sometimes odd, zero or oversized
  function automatic logic [12:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 13'(2 * $urandom_range(1, 6));
      6:                return 13'($urandom_range(0, 11));
      7:                return 13'(4096 + $urandom_range(0, 4095));
      8:                return 13'd640;
      default:          return 13'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_component();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted write against the oldest expectation
  always @(posedge clk) begin : check_writes
    yuv_write_t exp_wr;
    if (!rst && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected write: byte_address %0d byte_value %0d plane %0d",
               byte_address, byte_value, plane);
        error_count++;
      end else begin
        exp_wr = expected_writes.pop_front();
        writes_checked++;
        if (byte_address !== exp_wr.addr) begin
          $error("byte_address: expected %0d, got %0d", exp_wr.addr, byte_address);
          error_count++;
        end
        if (byte_value !== exp_wr.value) begin
          $error("byte_value: expected %0d, got %0d", exp_wr.value, byte_value);
          error_count++;
        end
        if (plane !== exp_wr.plane) begin
          $error("plane: expected %0d, got %0d", exp_wr.plane, plane);
          error_count++;
        end
        if (last_of_pixel !== exp_wr.lp) begin
          $error("last_of_pixel: expected %0d, got %0d", exp_wr.lp, last_of_pixel);
          error_count++;
        end
        if (last_of_frame !== exp_wr.lf) begin
          $error("last_of_frame: expected %0d, got %0d", exp_wr.lf, last_of_frame);
          error_count++;
        end
        if (exp_wr.lf) frames_done++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    idle_mode_t mode;
    int i;
    int p;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = rgyuv_pkg::REG_FRAME_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    red       = '0;
    green     = '0;
    blue      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners, no idling
    for (i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        settle();
        write_reg(directed_rows[i].cfg_sel, directed_rows[i].cfg_value);
      end else begin
        send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                   directed_rows[i].typed, directed_rows[i].ey, directed_rows[i].eu,
                   directed_rows[i].ev);
      end
    end

    // Random phases: new frame size each time, cycling through idle patterns
    for (p = 0; p < PHASE_COUNT; p++) begin
      settle();
      write_reg(rgyuv_pkg::REG_FRAME_WIDTH, pick_size());
      write_reg(rgyuv_pkg::REG_FRAME_HEIGHT, pick_size());
      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_SENDER: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        IDLE_BOTH: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      // Hold the result side off so the block backs up into its input
      if (p == 4) begin
        @(posedge clk);
        hold_off_left = HOLD_CYCLES;
        @(negedge clk);
      end
      for (i = 0; i < PHASE_PIXELS; i++) begin
        send_pixel(pick_component(), pick_component(), pick_component(),
                   1'b0, 8'd0, 8'd0, 8'd0);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();

    $display("Covered %0d pixels and %0d byte writes, %0d frame ends, %0d size writes,",
             pixels_sent, writes_checked, frames_done, sizes_written);
    $display("with idle, sender-gap, receiver-stall and long hold-off traffic.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### rgb_to_yuv420_planar_writer.f
rtl/rgyuv_pkg.sv
rtl/rgyuv_raster.sv
rtl/rgyuv_color.sv
rtl/rgyuv_emit.sv
rtl/rgb_to_yuv420_planar_writer.sv
tb/tb.sv
